[hdl/bounded_set_engine_defines.svh]
// ----------------------------------------------------------------------------
// bounded_set_engine_defines
// assertion macros shared by the set engine rtl
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_ENGINE_DEFINES_SVH
`define BOUNDED_SET_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_set_engine: assertion failed");

// next-cycle implication, checked out of reset
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_set_engine: assertion failed");

`endif

[hdl/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg
// shared types and constants of the bounded set engine
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  localparam int DATA_W          = 32;
  localparam int OP_W            = 3;
  localparam int STATUS_W        = 3;
  localparam int CAP_W           = 5;
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int MAX_RESULTS     = 32;
  localparam int RES_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // op codes
  localparam logic [OP_W-1:0] OP_ADD_A   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_B   = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY_A = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY_B = 3'd3;
  localparam logic [OP_W-1:0] OP_INTER   = 3'd4;
  localparam logic [OP_W-1:0] OP_UNION   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ADDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MEMBER = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd6;

  // register indexes
  localparam logic REG_CAPACITY_A = 1'b0;
  localparam logic REG_CAPACITY_B = 1'b1;

  // store control from the sequencer
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd_b;
  } bse_ctl_t;

endpackage

`default_nettype wire

[hdl/bse_store.sv]
// ----------------------------------------------------------------------------
// bse_store
// element memories of both sets with registered read and the shared comparator
// ----------------------------------------------------------------------------
`default_nettype none

module bse_store #(
  parameter int MAX_ENTRIES = bse_pkg::DEF_MAX_ENTRIES
) (
  input  wire                                               clk_i,
  input  wire  bse_pkg::bse_ctl_t                           ctl_i,
  input  wire  [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] waddr_i,
  input  wire  [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] raddr_i,
  input  wire  [bse_pkg::DATA_W-1:0]                        wdata_i,
  input  wire  [bse_pkg::DATA_W-1:0]                        key_i,
  output logic [bse_pkg::DATA_W-1:0]                        rdata_o,
  output logic                                              match_o
);
  import bse_pkg::*;

  logic [DATA_W-1:0] mem_a [MAX_ENTRIES];
  logic [DATA_W-1:0] mem_b [MAX_ENTRIES];
  logic [DATA_W-1:0] rd_a_q;
  logic [DATA_W-1:0] rd_b_q;
  logic              sel_b_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_a) begin
      mem_a[waddr_i] <= wdata_i;
    end
    if (ctl_i.wr_b) begin
      mem_b[waddr_i] <= wdata_i;
    end
    rd_a_q  <= mem_a[raddr_i];
    rd_b_q  <= mem_b[raddr_i];
    sel_b_q <= ctl_i.rd_b;
  end

  assign rdata_o = sel_b_q ? rd_b_q : rd_a_q;
  assign match_o = (rdata_o == key_i);

endmodule

`default_nettype wire

[hdl/bounded_set_engine.sv]
// ----------------------------------------------------------------------------
// bounded_set_engine
// two bounded sets of 32-bit integers with add, query, clear, intersection
// and union streaming
// ----------------------------------------------------------------------------
// One word is taken at a time; s_axis_tready is high only while the sequencer
// is idle. All work runs through one memory read port per set and a single
// 32-bit comparator, looking at one stored element at a time. Add and
// query scan the addressed set until a match or its end; a full add does
// not scan. Intersection scans B for each element of A, union emits A and
// then scans A for each element of B; the output side can stall. Results go
// out through a one-word output register and a one-word holding stage, so a
// stream is known to end before its last word is marked. The element
// memories are not cleared; only entries below each set's count are read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_set_engine_defines.svh"

module bounded_set_engine #(
  parameter int MAX_ENTRIES = bse_pkg::DEF_MAX_ENTRIES
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration
  input  wire                            cfg_we_i,
  input  wire                            cfg_idx_i,
  input  wire  [bse_pkg::CAP_W-1:0]      cfg_data_i,
  // input stream
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [bse_pkg::DATA_W-1:0]     s_axis_tdata,  // value
  input  wire  [bse_pkg::OP_W-1:0]       s_axis_tuser,  // op
  // result stream
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [bse_pkg::DATA_W-1:0]     m_axis_tdata,  // element
  output logic [bse_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
  output logic                           m_axis_tlast
);
  import bse_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam int          SQ_W     = 4;
  localparam [SQ_W-1:0]   S_IDLE   = 4'd0;
  localparam [SQ_W-1:0]   S_FETCH  = 4'd1;
  localparam [SQ_W-1:0]   S_CMP    = 4'd2;
  localparam [SQ_W-1:0]   S_RESULT = 4'd3;
  localparam [SQ_W-1:0]   S_OFETCH = 4'd4;
  localparam [SQ_W-1:0]   S_OKEY   = 4'd5;
  localparam [SQ_W-1:0]   S_ADV    = 4'd6;
  localparam [SQ_W-1:0]   S_EMIT   = 4'd7;
  localparam [SQ_W-1:0]   S_FINAL  = 4'd8;
  localparam [SQ_W-1:0]   S_FLUSH  = 4'd9;

  logic [SQ_W-1:0]     state_q, state_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [CNT_W-1:0]    cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CAP_W-1:0]    cap_a_q, cap_b_q;
  logic [CNT_W-1:0]    idx_q, idx_d, oidx_q, oidx_d, scan_n_q, scan_n_d;
  logic                scan_b_q, scan_b_d, hit_q, hit_d, phase_q, phase_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                pend_v_q, pend_v_d;
  logic [RES_W-1:0]    res_cnt_q, res_cnt_d;
  logic                m_valid_q, m_valid_d;

  logic [DATA_W-1:0]   value_q, value_d, key_q, key_d, pend_q, pend_d;
  logic [DATA_W-1:0]   m_elem_q, m_elem_d;
  logic [STATUS_W-1:0] m_status_q, m_status_d;
  logic                m_last_q, m_last_d;

  bse_ctl_t            ctl;
  logic [IDX_W-1:0]    raddr, waddr;
  logic [DATA_W-1:0]   rdata;
  logic                match;
  logic                out_free, full_a, full_b, in_acc;
  logic [CNT_W-1:0]    oidx_nx, olimit;

  bse_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .wdata_i (value_q),
    .key_i   (key_q),
    .rdata_o (rdata),
    .match_o (match)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign full_a        = (CMP_W'(cnt_a_q) >= CMP_W'(cap_a_q)) ||
                         (cnt_a_q == CNT_W'(MAX_ENTRIES));
  assign full_b        = (CMP_W'(cnt_b_q) >= CMP_W'(cap_b_q)) ||
                         (cnt_b_q == CNT_W'(MAX_ENTRIES));
  assign oidx_nx       = oidx_q + CNT_W'(1);
  assign olimit        = phase_q ? cnt_b_q : cnt_a_q;
  assign waddr         = (op_q == OP_ADD_A) ? cnt_a_q[IDX_W-1:0] : cnt_b_q[IDX_W-1:0];

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    idx_d      = idx_q;
    oidx_d     = oidx_q;
    scan_n_d   = scan_n_q;
    scan_b_d   = scan_b_q;
    hit_d      = hit_q;
    phase_d    = phase_q;
    status_d   = status_q;
    pend_v_d   = pend_v_q;
    res_cnt_d  = res_cnt_q;
    value_d    = value_q;
    key_d      = key_q;
    pend_d     = pend_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_elem_d   = m_elem_q;
    m_status_d = m_status_q;
    m_last_d   = m_last_q;
    ctl        = '0;
    raddr      = idx_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d      = s_axis_tuser;
          value_d   = s_axis_tdata;
          key_d     = s_axis_tdata;
          idx_d     = '0;
          oidx_d    = '0;
          hit_d     = 1'b0;
          phase_d   = 1'b0;
          res_cnt_d = '0;
          case (s_axis_tuser)
            OP_ADD_A, OP_QUERY_A: begin
              scan_b_d = 1'b0;
              scan_n_d = cnt_a_q;
              if ((s_axis_tuser == OP_ADD_A) && full_a) begin
                status_d = ST_FULL;
                state_d  = S_FINAL;
              end else begin
                state_d = (cnt_a_q == '0) ? S_RESULT : S_FETCH;
              end
            end
            OP_ADD_B, OP_QUERY_B: begin
              scan_b_d = 1'b1;
              scan_n_d = cnt_b_q;
              if ((s_axis_tuser == OP_ADD_B) && full_b) begin
                status_d = ST_FULL;
                state_d  = S_FINAL;
              end else begin
                state_d = (cnt_b_q == '0) ? S_RESULT : S_FETCH;
              end
            end
            OP_INTER: begin
              state_d = (cnt_a_q == '0) ? S_FLUSH : S_OFETCH;
            end
            OP_UNION: begin
              if (cnt_a_q != '0) begin
                state_d = S_OFETCH;
              end else if (cnt_b_q != '0) begin
                phase_d = 1'b1;
                state_d = S_OFETCH;
              end else begin
                state_d = S_FLUSH;
              end
            end
            OP_CLEAR: begin
              cnt_a_d  = '0;
              cnt_b_d  = '0;
              status_d = ST_EMPTY;
              state_d  = S_FINAL;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_FETCH: begin
        ctl.rd_b = scan_b_q;
        state_d  = S_CMP;
      end

      S_CMP: begin
        if (match) begin
          hit_d   = 1'b1;
          state_d = S_RESULT;
        end else if ((idx_q + CNT_W'(1)) == scan_n_q) begin
          state_d = S_RESULT;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_FETCH;
        end
      end

      S_RESULT: begin
        case (op_q)
          OP_ADD_A: begin
            status_d = hit_q ? ST_DUP : ST_ADDED;
            if (!hit_q) begin
              ctl.wr_a = 1'b1;
              cnt_a_d  = cnt_a_q + CNT_W'(1);
            end
            state_d = S_FINAL;
          end
          OP_ADD_B: begin
            status_d = hit_q ? ST_DUP : ST_ADDED;
            if (!hit_q) begin
              ctl.wr_b = 1'b1;
              cnt_b_d  = cnt_b_q + CNT_W'(1);
            end
            state_d = S_FINAL;
          end
          OP_QUERY_A, OP_QUERY_B: begin
            status_d = hit_q ? ST_FOUND : ST_ABSENT;
            state_d  = S_FINAL;
          end
          OP_INTER: begin
            state_d = hit_q ? S_EMIT : S_ADV;
          end
          default: begin
            state_d = hit_q ? S_ADV : S_EMIT;
          end
        endcase
      end

      S_OFETCH: begin
        raddr    = oidx_q[IDX_W-1:0];
        ctl.rd_b = phase_q;
        state_d  = S_OKEY;
      end

      S_OKEY: begin
        key_d = rdata;
        idx_d = '0;
        hit_d = 1'b0;
        if (op_q == OP_INTER) begin
          scan_b_d = 1'b1;
          scan_n_d = cnt_b_q;
          state_d  = (cnt_b_q == '0) ? S_RESULT : S_FETCH;
        end else if (!phase_q) begin
          state_d = S_EMIT;
        end else begin
          scan_b_d = 1'b0;
          scan_n_d = cnt_a_q;
          state_d  = (cnt_a_q == '0) ? S_RESULT : S_FETCH;
        end
      end

      S_ADV: begin
        if (oidx_nx != olimit) begin
          oidx_d  = oidx_nx;
          state_d = S_OFETCH;
        end else if ((op_q == OP_UNION) && !phase_q && (cnt_b_q != '0)) begin
          phase_d = 1'b1;
          oidx_d  = '0;
          state_d = S_OFETCH;
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_EMIT: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            m_valid_d  = 1'b1;
            m_elem_d   = pend_q;
            m_status_d = ST_MEMBER;
            m_last_d   = 1'b0;
          end
          pend_d    = key_q;
          pend_v_d  = 1'b1;
          res_cnt_d = res_cnt_q + RES_W'(1);
          state_d   = ((res_cnt_q + RES_W'(1)) == RES_W'(MAX_RESULTS)) ? S_FLUSH : S_ADV;
        end
      end

      S_FINAL: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_elem_d   = value_q;
          m_status_d = status_q;
          m_last_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_elem_d   = pend_v_q ? pend_q : value_q;
          m_status_d = pend_v_q ? ST_MEMBER : ST_EMPTY;
          m_last_d   = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_CLEAR;
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      cap_a_q   <= CAP_RESET;
      cap_b_q   <= CAP_RESET;
      idx_q     <= '0;
      oidx_q    <= '0;
      scan_n_q  <= '0;
      scan_b_q  <= 1'b0;
      hit_q     <= 1'b0;
      phase_q   <= 1'b0;
      status_q  <= ST_EMPTY;
      pend_v_q  <= 1'b0;
      res_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      idx_q     <= idx_d;
      oidx_q    <= oidx_d;
      scan_n_q  <= scan_n_d;
      scan_b_q  <= scan_b_d;
      hit_q     <= hit_d;
      phase_q   <= phase_d;
      status_q  <= status_d;
      pend_v_q  <= pend_v_d;
      res_cnt_q <= res_cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY_A: cap_a_q <= cfg_data_i;
          REG_CAPACITY_B: cap_b_q <= cfg_data_i;
          default: begin
            cap_a_q <= cap_a_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    key_q      <= key_d;
    pend_q     <= pend_d;
    m_elem_q   <= m_elem_d;
    m_status_q <= m_status_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_elem_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

  `BSE_ASSERT_IMPL(a_idle_no_pending, clk_i, rst_ni, state_q == S_IDLE, !pend_v_q)
  `BSE_ASSERT_IMPL(a_counts_bounded, clk_i, rst_ni, 1'b1,
                   (cnt_a_q <= CNT_W'(MAX_ENTRIES)) && (cnt_b_q <= CNT_W'(MAX_ENTRIES)))
  `BSE_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni,
                   s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CLEAR),
                   (cnt_a_q == '0) && (cnt_b_q == '0))
  `BSE_ASSERT_IMPL(a_open_stream_held, clk_i, rst_ni,
                   m_axis_tvalid && !m_axis_tlast, pend_v_q)

endmodule

`default_nettype wire
